// ===== rtl/core/i2c_slave_address_assignment_fsm_core_assert.svh =====
// Assertion macros for the I2C slave address-assignment core.
`ifndef I2C_SLAVE_ADDRESS_ASSIGNMENT_FSM_CORE_ASSERT_SVH
`define I2C_SLAVE_ADDRESS_ASSIGNMENT_FSM_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define I2CAA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2c address-assignment core: check failed");

// Next-cycle implication, disabled in reset.
`define I2CAA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2c address-assignment core: check failed");

`endif

// ===== rtl/core/i2caa_pkg.sv =====
// Types, codes and helpers for the I2C slave address-assignment core.
package i2caa_pkg;

  localparam int ID_BYTES     = 8;
  localparam int RECORD_BYTES = 16;

  // Slave status codes (already masked with 0xF8)
  localparam logic [7:0] BS_BUS_ERROR        = 8'h00;
  localparam logic [7:0] BS_SR_SLA_ACK       = 8'h60;
  localparam logic [7:0] BS_SR_GCALL_ACK     = 8'h70;
  localparam logic [7:0] BS_SR_DATA_ACK      = 8'h80;
  localparam logic [7:0] BS_SR_DATA_NACK     = 8'h88;
  localparam logic [7:0] BS_SR_GCALL_DAT_ACK = 8'h90;
  localparam logic [7:0] BS_SR_GCALL_DAT_NAK = 8'h98;
  localparam logic [7:0] BS_SR_STOP          = 8'hA0;
  localparam logic [7:0] BS_ST_SLA_ACK       = 8'hA8;
  localparam logic [7:0] BS_ST_DATA_ACK      = 8'hB8;
  localparam logic [7:0] BS_ST_DATA_NACK     = 8'hC0;
  localparam logic [7:0] BS_ST_LAST_DATA     = 8'hC8;

  // Bit actions
  localparam logic [1:0] ACT_KEEP = 2'd0;
  localparam logic [1:0] ACT_SET  = 2'd1;
  localparam logic [1:0] ACT_CLR  = 2'd2;

  // Reported state codes
  localparam logic [2:0] FS_IDLE        = 3'd0;
  localparam logic [2:0] FS_ADDRESSED   = 3'd1;
  localparam logic [2:0] FS_GETCFG_ADDR = 3'd2;
  localparam logic [2:0] FS_ASSIGN_ID   = 3'd3;
  localparam logic [2:0] FS_ASSIGN_ADDR = 3'd4;
  localparam logic [2:0] FS_SENDING     = 3'd5;

  // Configuration register indexes
  localparam logic [2:0] CFG_GCALL_ADDR  = 3'd0;
  localparam logic [2:0] CFG_CMD_RST_DEV = 3'd1;
  localparam logic [2:0] CFG_CMD_RST_PRM = 3'd2;
  localparam logic [2:0] CFG_CMD_GET_CFG = 3'd3;
  localparam logic [2:0] CFG_CMD_ASSIGN  = 3'd4;
  localparam logic [2:0] CFG_UNIQUE_ID   = 3'd5;
  localparam logic [2:0] CFG_RECORD_TAIL = 3'd6;
  localparam logic [2:0] CFG_PERM_INIT   = 3'd7;

  typedef enum logic [5:0] {
    S_IDLE        = 6'b000001,
    S_ADDRESSED   = 6'b000010,
    S_GETCFG_ADDR = 6'b000100,
    S_ASSIGN_ID   = 6'b001000,
    S_ASSIGN_ADDR = 6'b010000,
    S_SENDING     = 6'b100000
  } state_t;

  typedef enum logic [2:0] {
    LC_NONE       = 3'd0,
    LC_RESET_DEV  = 3'd1,
    LC_RESET_PERM = 3'd2,
    LC_GET_CONFIG = 3'd3,
    LC_ASSIGN     = 3'd4
  } last_cmd_t;

  typedef struct packed {
    logic [7:0] bus_status;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0] ea_action;
    logic [1:0] sto_action;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       addr_valid;
    logic [7:0] own_address;
    logic       nv_write;
    logic [7:0] nv_byte;
    logic [2:0] fsm_state;
  } out_t;

  // Byte i of a 64-bit word; zero past the word
  function automatic logic [7:0] byte_of(input logic [63:0] w, input logic [4:0] i);
    logic [7:0] b;
    b = 8'h00;
    if (i[4:3] == 2'b00) begin
      b = w[{i[2:0], 3'b000} +: 8];
    end
    return b;
  endfunction

  function automatic logic [2:0] state_code(input state_t s);
    logic [2:0] c;
    unique case (s)
      S_IDLE:        c = FS_IDLE;
      S_ADDRESSED:   c = FS_ADDRESSED;
      S_GETCFG_ADDR: c = FS_GETCFG_ADDR;
      S_ASSIGN_ID:   c = FS_ASSIGN_ID;
      S_ASSIGN_ADDR: c = FS_ASSIGN_ADDR;
      S_SENDING:     c = FS_SENDING;
      default:       c = FS_IDLE;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/i2c_slave_address_assignment_fsm_core.sv =====
// Top level of the I2C slave address-assignment core.
// Each item is one slave event (status code and data byte) and yields exactly one
// result item: acknowledge and stop bit actions, a transmit byte, an own-address
// update and a nonvolatile address write, plus the protocol state after the event.
// An item is latched in an input register, decoded combinationally against the protocol
// state and written to the result register, so one item per clock is sustained while
// results are taken; the state update is the only loop. The input
// register keeps taking items while a result waits to be taken, until both are full.
// Configuration writes take effect at once and are meant for idle periods only.
module i2c_slave_address_assignment_fsm_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  i2caa_pkg::in_t    in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output i2caa_pkg::out_t   out_item,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [63:0]       cfg_data
);
  import i2caa_pkg::*;

  // Configuration
  logic [7:0]  gcall_addr;
  logic [7:0]  cmd_rst_dev;
  logic [7:0]  cmd_rst_perm;
  logic [7:0]  cmd_get_cfg;
  logic [7:0]  cmd_assign;
  logic [63:0] unique_id;
  logic [63:0] record_tail;

  // Protocol state
  state_t      state, state_next;
  last_cmd_t   last_cmd, last_cmd_next;
  logic [7:0]  soft_addr, soft_addr_next;
  logic [7:0]  perm_addr, perm_addr_next;
  logic [7:0]  sent_byte, sent_byte_next;
  logic [4:0]  byte_count, byte_count_next;

  // Input stage
  logic        s1_valid;
  in_t         s1_item;
  logic        advance;

  out_t        res_next;
  logic        gen_rst, rel_tx, rel_rx, set_own;
  logic [7:0]  st, rx;
  logic [4:0]  count_inc;
  logic [4:0]  tail_idx;
  logic [7:0]  rec_byte;

  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  assign st        = s1_item.bus_status;
  assign rx        = s1_item.rx_byte;
  assign count_inc = byte_count + 5'd1;
  assign tail_idx  = byte_count - 5'(ID_BYTES);
  assign rec_byte  = (byte_count < 5'(ID_BYTES)) ? byte_of(unique_id, byte_count)
                                                 : byte_of(record_tail, tail_idx);

  always_comb begin
    state_next      = state;
    last_cmd_next   = last_cmd;
    soft_addr_next  = soft_addr;
    perm_addr_next  = perm_addr;
    sent_byte_next  = sent_byte;
    byte_count_next = byte_count;
    res_next        = '0;
    gen_rst         = 1'b0;
    rel_tx          = 1'b0;
    rel_rx          = 1'b0;
    set_own         = 1'b0;

    if (st == BS_SR_STOP) begin
      state_next          = S_IDLE;
      res_next.ea_action  = ACT_SET;
      res_next.sto_action = ACT_CLR;
    end else begin
      unique case (state)
        S_IDLE: begin
          case (st) inside
            BS_SR_SLA_ACK: begin
              last_cmd_next = LC_NONE;
              gen_rst       = 1'b1;
            end
            BS_SR_GCALL_ACK: state_next = S_ADDRESSED;
            BS_ST_SLA_ACK: begin
              if ((rx & 8'hFE) == gcall_addr) begin
                if (last_cmd == LC_GET_CONFIG) begin
                  sent_byte_next    = 8'(RECORD_BYTES);
                  res_next.tx_valid = 1'b1;
                  res_next.tx_byte  = 8'(RECORD_BYTES);
                  state_next        = S_SENDING;
                  byte_count_next   = 5'd0;
                end else begin
                  rel_tx = 1'b1;
                end
              end else begin
                gen_rst = 1'b1;
              end
            end
            BS_ST_LAST_DATA, BS_SR_STOP: begin
              res_next.ea_action  = ACT_SET;
              res_next.sto_action = ACT_CLR;
            end
            BS_ST_DATA_ACK, BS_SR_DATA_ACK, BS_SR_GCALL_DAT_ACK: rel_rx = 1'b1;
            BS_BUS_ERROR, BS_ST_DATA_NACK, BS_SR_DATA_NACK, BS_SR_GCALL_DAT_NAK:
              rel_tx = 1'b1;
            default: begin
              res_next.ea_action  = ACT_SET;
              res_next.sto_action = ACT_SET;
            end
          endcase
        end
        S_ADDRESSED: begin
          if (st != BS_SR_GCALL_DAT_ACK) begin
            gen_rst = 1'b1;
          end else if (rx == cmd_rst_dev) begin
            last_cmd_next  = LC_RESET_DEV;
            state_next     = S_IDLE;
            soft_addr_next = 8'h00;
            set_own        = 1'b1;
          end else if (rx == cmd_rst_perm) begin
            last_cmd_next  = (perm_addr != 8'h00) ? LC_NONE : LC_RESET_PERM;
            state_next     = S_IDLE;
            soft_addr_next = perm_addr;
            set_own        = 1'b1;
          end else if (rx == cmd_get_cfg) begin
            last_cmd_next = LC_GET_CONFIG;
            state_next    = S_GETCFG_ADDR;
          end else if (rx == cmd_assign) begin
            last_cmd_next   = LC_ASSIGN;
            byte_count_next = 5'd0;
            state_next      = S_ASSIGN_ID;
          end else begin
            rel_rx = 1'b1;
          end
        end
        S_GETCFG_ADDR: begin
          if (st == BS_SR_GCALL_DAT_ACK) begin
            state_next          = S_IDLE;
            res_next.ea_action  = ACT_SET;
            res_next.sto_action = ACT_SET;
            if (soft_addr != rx) begin
              last_cmd_next = LC_NONE;
            end
          end else begin
            gen_rst = 1'b1;
          end
        end
        S_ASSIGN_ID: begin
          if (st == BS_SR_GCALL_DAT_ACK) begin
            if (rx == byte_of(unique_id, byte_count)) begin
              byte_count_next = count_inc;
              if (count_inc == 5'(ID_BYTES)) begin
                state_next = S_ASSIGN_ADDR;
              end
            end else begin
              rel_rx = 1'b1;
            end
          end else begin
            gen_rst = 1'b1;
          end
        end
        S_ASSIGN_ADDR: begin
          if (st == BS_SR_GCALL_DAT_ACK) begin
            soft_addr_next = {rx[7:1], 1'b0};
            if (rx[0]) begin
              perm_addr_next    = {rx[7:1], 1'b0};
              res_next.nv_write = 1'b1;
              res_next.nv_byte  = {rx[7:1], 1'b0};
            end
            state_next          = S_IDLE;
            set_own             = 1'b1;
            res_next.ea_action  = ACT_SET;
            res_next.sto_action = ACT_SET;
            last_cmd_next       = LC_NONE;
          end else begin
            gen_rst = 1'b1;
          end
        end
        S_SENDING: begin
          if (st == BS_ST_DATA_ACK) begin
            if (rx != sent_byte) begin
              rel_tx = 1'b1;
            end else begin
              sent_byte_next    = rec_byte;
              res_next.tx_valid = 1'b1;
              res_next.tx_byte  = rec_byte;
              byte_count_next   = count_inc;
              if (count_inc == 5'(RECORD_BYTES)) begin
                state_next         = S_IDLE;
                res_next.ea_action = ACT_CLR;
              end else begin
                res_next.ea_action = ACT_SET;
              end
            end
          end else begin
            gen_rst = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // Common reset path for unexpected events
    if (gen_rst) begin
      case (st) inside
        BS_ST_LAST_DATA, BS_SR_STOP, BS_ST_DATA_NACK, BS_SR_DATA_NACK,
        BS_SR_GCALL_DAT_NAK: begin
          state_next          = S_IDLE;
          res_next.ea_action  = ACT_SET;
          res_next.sto_action = ACT_CLR;
        end
        BS_BUS_ERROR: rel_tx = 1'b1;
        default:      rel_rx = 1'b1;
      endcase
    end

    if (rel_tx) begin
      state_next          = S_IDLE;
      last_cmd_next       = LC_NONE;
      res_next.tx_valid   = 1'b1;
      res_next.tx_byte    = 8'hFF;
      res_next.ea_action  = ACT_SET;
      res_next.sto_action = ACT_SET;
    end
    if (rel_rx) begin
      state_next          = S_IDLE;
      last_cmd_next       = LC_NONE;
      res_next.tx_valid   = 1'b1;
      res_next.tx_byte    = 8'hFF;
      res_next.ea_action  = ACT_CLR;
      res_next.sto_action = ACT_SET;
    end
    if (set_own) begin
      res_next.addr_valid  = 1'b1;
      res_next.own_address = soft_addr_next | 8'h01;
    end
    res_next.fsm_state = state_code(state_next);
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_item <= in_item;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (advance) begin
      out_item <= res_next;
    end
  end

  // Protocol state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      last_cmd     <= LC_NONE;
      soft_addr    <= 8'h00;
      perm_addr    <= 8'h00;
      sent_byte    <= 8'h00;
      byte_count   <= 5'd0;
      gcall_addr   <= 8'h00;
      cmd_rst_dev  <= 8'h01;
      cmd_rst_perm <= 8'h02;
      cmd_get_cfg  <= 8'h03;
      cmd_assign   <= 8'h04;
      unique_id    <= 64'd0;
      record_tail  <= 64'd0;
    end else begin
      if (advance) begin
        state      <= state_next;
        last_cmd   <= last_cmd_next;
        soft_addr  <= soft_addr_next;
        perm_addr  <= perm_addr_next;
        sent_byte  <= sent_byte_next;
        byte_count <= byte_count_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_GCALL_ADDR:  gcall_addr   <= cfg_data[7:0];
          CFG_CMD_RST_DEV: cmd_rst_dev  <= cfg_data[7:0];
          CFG_CMD_RST_PRM: cmd_rst_perm <= cfg_data[7:0];
          CFG_CMD_GET_CFG: cmd_get_cfg  <= cfg_data[7:0];
          CFG_CMD_ASSIGN:  cmd_assign   <= cfg_data[7:0];
          CFG_UNIQUE_ID:   unique_id    <= cfg_data;
          CFG_RECORD_TAIL: record_tail  <= cfg_data;
          CFG_PERM_INIT:   perm_addr    <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

`include "i2c_slave_address_assignment_fsm_core_assert.svh"

  `I2CAA_ASSERT_NEXT(a_result_follows, advance, out_valid)
  `I2CAA_ASSERT_NOW(a_nv_with_own, out_valid && out_item.nv_write, out_item.addr_valid && (out_item.own_address == (out_item.nv_byte | 8'h01)))
  `I2CAA_ASSERT_NOW(a_sending_loads_tx, out_valid && (out_item.fsm_state == FS_SENDING), out_item.tx_valid)

endmodule
